// ----- sv/clpt_pkg.sv -----
package clpt_pkg;

  localparam int CMD_W  = 2;
  localparam int CH_W   = 7;
  localparam int LVL_W  = 7;
  localparam int GAIN_W = 3;

  localparam logic [LVL_W-1:0]  LEVEL_MAX = 7'd100;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 3'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_MEAS  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef struct packed {
    logic capture;
    logic rd_meas;
    logic walk_start;
    logic walk_rd;
    logic meas_upd;
    logic load_zero;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic in_range;
    logic walk_last;
  } ctrl_sts_t;

  // min(25*gain, 100)
  function automatic logic [LVL_W-1:0] attack_step(input logic [GAIN_W-1:0] g);
    logic [LVL_W-1:0] s;
    unique case (g)
      3'd0:    s = 7'd0;
      3'd1:    s = 7'd25;
      3'd2:    s = 7'd50;
      3'd3:    s = 7'd75;
      default: s = LEVEL_MAX;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/clpt_if.sv -----
interface clpt_in_if import clpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CH_W-1:0]   channel_index;
  logic              detected;

  modport source (output valid, command, channel_index, detected, input ready);
  modport sink   (input valid, command, channel_index, detected, output ready);
endinterface

interface clpt_out_if import clpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LVL_W-1:0]  level;
  logic [LVL_W-1:0]  peak;
  logic              sweep_done;
  logic [CH_W-1:0]   busiest_channel;
  logic [LVL_W-1:0]  busiest_level;

  modport source (output valid, level, peak, sweep_done, busiest_channel, busiest_level,
                  input ready);
  modport sink   (input valid, level, peak, sweep_done, busiest_channel, busiest_level,
                  output ready);
endinterface

// ----- sv/clpt_dp.sv -----
module clpt_dp import clpt_pkg::*; #(
  parameter int NUM_CHANNELS = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [GAIN_W-1:0] cfg_wdata,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [CH_W-1:0]   in_channel_index,
  input  logic              in_detected,
  input  ctrl_cmd_t         cmd,
  output ctrl_sts_t         sts,
  output logic [LVL_W-1:0]  out_level,
  output logic [LVL_W-1:0]  out_peak,
  output logic              out_sweep_done,
  output logic [CH_W-1:0]   out_busiest_channel,
  output logic [LVL_W-1:0]  out_busiest_level
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [AW-1:0]   LAST_ADDR = AW'(NUM_CHANNELS - 1);
  localparam logic [CH_W-1:0] LAST_CH   = CH_W'(NUM_CHANNELS - 1);
  localparam logic [CH_W:0]   NCH       = (CH_W + 1)'(NUM_CHANNELS);

  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [LVL_W-1:0] pk;
  } ent_t;

  ent_t                mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;

  logic [GAIN_W-1:0]   gain_r;
  cmd_t                cmd_r;
  logic [CH_W-1:0]     ch_r;
  logic                det_r;

  ent_t                rdata_r;
  logic                rd_vld_r;
  logic [AW-1:0]       walk_cnt_r;
  logic                wb_v_r;
  logic [AW-1:0]       wb_addr_r;

  logic [CH_W-1:0]     smax_ch_r;
  logic [LVL_W-1:0]    smax_lvl_r;

  logic [AW-1:0]       ch_addr;
  logic [AW-1:0]       raddr;
  logic [LVL_W-1:0]    old_lvl;
  logic [LVL_W-1:0]    old_pk;
  logic [LVL_W:0]      sum;
  logic [LVL_W+1:0]    x3;
  logic [LVL_W-1:0]    new_lvl;
  logic [LVL_W-1:0]    new_pk;
  logic                last_ch;
  logic                smax_upd;
  logic [CH_W-1:0]     cand_ch;
  logic [LVL_W-1:0]    cand_lvl;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  ent_t                wr_data;

  assign ch_addr = ch_r[AW-1:0];
  assign raddr   = cmd.walk_rd ? walk_cnt_r : ch_addr;

  assign old_lvl = rd_vld_r ? rdata_r.lvl : '0;
  assign old_pk  = rd_vld_r ? rdata_r.pk  : '0;
  assign sum     = {1'b0, old_lvl} + {1'b0, attack_step(gain_r)};
  assign x3      = {2'b00, old_lvl} + {1'b0, old_lvl, 1'b0};

  always_comb begin
    if (det_r) begin
      new_lvl = (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[LVL_W-1:0];
    end else begin
      new_lvl = x3[LVL_W+1:2];
    end
    new_pk = (new_lvl > old_pk) ? new_lvl : old_pk;
  end

  assign last_ch  = (ch_r == LAST_CH);
  assign smax_upd = (new_lvl > smax_lvl_r) || ((new_lvl == smax_lvl_r) && (ch_r < smax_ch_r));
  assign cand_ch  = smax_upd ? ch_r : smax_ch_r;
  assign cand_lvl = smax_upd ? new_lvl : smax_lvl_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ch_addr;
    wr_data = '{lvl: new_lvl, pk: new_pk};
    if (cmd.meas_upd) begin
      wr_en = 1'b1;
    end else if (wb_v_r && rd_vld_r && (rdata_r.pk > rdata_r.lvl)) begin
      wr_en   = 1'b1;
      wr_addr = wb_addr_r;
      wr_data = '{lvl: rdata_r.lvl, pk: rdata_r.pk - 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_meas || cmd.walk_rd) begin
      rdata_r  <= mem[raddr];
      rd_vld_r <= vld_r[raddr];
    end
    wb_addr_r <= walk_cnt_r;
    if (cmd.capture) begin
      ch_r  <= in_channel_index;
      det_r <= in_detected;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= GAIN_RST;
      cmd_r      <= CMD_MEAS;
      vld_r      <= '0;
      walk_cnt_r <= '0;
      wb_v_r     <= 1'b0;
      smax_ch_r  <= '0;
      smax_lvl_r <= '0;
    end else begin
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
      if (cmd.capture) begin
        cmd_r <= cmd_t'(in_command);
      end
      if (cmd.clear) begin
        vld_r <= '0;
      end else if (cmd.meas_upd) begin
        vld_r[ch_addr] <= 1'b1;
      end
      if (cmd.walk_start) begin
        walk_cnt_r <= '0;
      end else if (cmd.walk_rd) begin
        walk_cnt_r <= walk_cnt_r + 1'b1;
      end
      wb_v_r <= cmd.walk_rd;
      if (cmd.clear || (cmd.meas_upd && last_ch)) begin
        smax_ch_r  <= '0;
        smax_lvl_r <= '0;
      end else if (cmd.meas_upd) begin
        smax_ch_r  <= cand_ch;
        smax_lvl_r <= cand_lvl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.meas_upd) begin
      out_level           <= new_lvl;
      out_peak            <= new_pk;
      out_sweep_done      <= last_ch;
      out_busiest_channel <= last_ch ? cand_ch : '0;
      out_busiest_level   <= last_ch ? cand_lvl : '0;
    end else if (cmd.load_zero) begin
      out_level           <= '0;
      out_peak            <= '0;
      out_sweep_done      <= 1'b0;
      out_busiest_channel <= '0;
      out_busiest_level   <= '0;
    end
  end

  assign sts.cmd       = cmd_r;
  assign sts.in_range  = ({1'b0, ch_r} < NCH);
  assign sts.walk_last = (walk_cnt_r == LAST_ADDR);

endmodule

// ----- sv/clpt_ctrl.sv -----
module clpt_ctrl import clpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_CALC  = 6'b000100,
    S_WALK  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        unique case (sts.cmd)
          CMD_MEAS: begin
            if (sts.in_range) begin
              cmd.rd_meas = 1'b1;
              state_nxt   = S_CALC;
            end else begin
              state_nxt = S_RESP;
            end
          end
          CMD_TICK: begin
            cmd.walk_start = 1'b1;
            state_nxt      = S_WALK;
          end
          CMD_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_RESP;
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_CALC: begin
        if (out_free) begin
          cmd.meas_upd = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walk_rd = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.load_zero = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.meas_upd || cmd.load_zero) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.meas_upd || cmd.load_zero) |-> (!out_valid_r || out_ready))
    else $error("output word overwritten");

  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_READ))
    else $error("accepted word not decoded");

  a_walk_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_rd |-> !(cmd.meas_upd || cmd.clear || cmd.rd_meas))
    else $error("walk overlaps measurement");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.meas_upd || cmd.load_zero) |=> (state_r == S_IDLE))
    else $error("result load not followed by idle");

endmodule

// ----- sv/channel_level_peak_tracker.sv -----
// Measurement: read in S_READ, update in S_CALC once the output is free.
// Clear or unknown command: S_RESP. Tick: walk every entry (one entry per
// cycle), S_DRAIN, S_RESP. Each word ends its read-modify-write of the single
// level/peak memory before the next. A new word is taken while a result waits.
// Reset (rst_n, synchronous): per-entry valid bits cleared so all levels and
// peaks read zero at once, running maximum zeroed, gain back to 2.
module channel_level_peak_tracker import clpt_pkg::*; #(
  parameter int NUM_CHANNELS = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  clpt_in_if.sink           in_ch,
  clpt_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [GAIN_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  clpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  clpt_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_command          (in_ch.command),
    .in_channel_index    (in_ch.channel_index),
    .in_detected         (in_ch.detected),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_level           (out_ch.level),
    .out_peak            (out_ch.peak),
    .out_sweep_done      (out_ch.sweep_done),
    .out_busiest_channel (out_ch.busiest_channel),
    .out_busiest_level   (out_ch.busiest_level)
  );

endmodule
